FILE: sv/rft_pkg.sv
// ----------------------------------------------------------------------------
// rft_pkg
// Types and constants shared by the four-thirds resampler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rft_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 15;
   localparam int DATA_W    = 24;
   localparam int OP_W      = 26;
   localparam int PROD_W    = 42;
   localparam int SHIFT_W   = 27;
   localparam int FRAC_SH   = 15;
   localparam int PHASE_W   = 2;
   localparam int UP_W      = 2;
   localparam int UP_LAST   = 2;
   localparam int COEF_REGS = 3;
   localparam int SEL_W     = 2;
   localparam int NUM_REGS  = 6;
   localparam int IDX_W     = 3;
   localparam int ADDR_W    = 5;
   localparam int PDATA_W   = 32;

   localparam logic [IDX_W-1:0] REG_FB_ONE    = 3'd0;
   localparam logic [IDX_W-1:0] REG_FB_TWO    = 3'd1;
   localparam logic [IDX_W-1:0] REG_FB_THREE  = 3'd2;
   localparam logic [IDX_W-1:0] REG_GAIN_ONE  = 3'd3;
   localparam logic [IDX_W-1:0] REG_GAIN_TWO  = 3'd4;
   localparam logic [IDX_W-1:0] REG_GAIN_THREE = 3'd5;

   typedef logic [COEF_W-1:0] coef_type;

   localparam coef_type REG_RESET [NUM_REGS] = '{
      15'd19293, 15'd5622, 15'd568, 15'd13015, 15'd9598, 15'd8334
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_SUM,
      ST_MUL2,
      ST_SAT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             accept;
      logic             mul1;
      logic             sum;
      logic             mul2;
      logic             sat;
      logic             emit;
      logic             advance;
      logic [SEL_W-1:0] coef_sel;
   } cmd_type;

   typedef struct packed {
      logic phase_zero;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: sv/rft_regs.sv
// ----------------------------------------------------------------------------
// rft_regs
// Register bank for the section feedback coefficients and gains.
// ----------------------------------------------------------------------------
`default_nettype none

module rft_regs (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [rft_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [rft_pkg::PDATA_W-1:0]   pwdata,
   output logic      [rft_pkg::PDATA_W-1:0]   prdata,
   output rft_pkg::coef_type                  fb_coef [rft_pkg::COEF_REGS],
   output rft_pkg::coef_type                  gain    [rft_pkg::COEF_REGS]
);

   rft_pkg::coef_type              regs_ff [rft_pkg::NUM_REGS];
   rft_pkg::coef_type              regs_in [rft_pkg::NUM_REGS];
   logic [rft_pkg::IDX_W-1:0]      idx;
   logic                           wr_en;

   assign idx   = paddr[rft_pkg::ADDR_W-1:2];
   assign wr_en = psel & penable & pwrite;

   always_comb begin
      prdata = '0;
      for (int i = 0; i < rft_pkg::NUM_REGS; i++) begin
         regs_in[i] = regs_ff[i];
         if (idx == rft_pkg::IDX_W'(i)) begin
            prdata = rft_pkg::PDATA_W'(regs_ff[i]);
            if (wr_en) begin
               regs_in[i] = pwdata[rft_pkg::COEF_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= rft_pkg::REG_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign fb_coef[0] = regs_ff[rft_pkg::REG_FB_ONE];
   assign fb_coef[1] = regs_ff[rft_pkg::REG_FB_TWO];
   assign fb_coef[2] = regs_ff[rft_pkg::REG_FB_THREE];
   assign gain[0]    = regs_ff[rft_pkg::REG_GAIN_ONE];
   assign gain[1]    = regs_ff[rft_pkg::REG_GAIN_TWO];
   assign gain[2]    = regs_ff[rft_pkg::REG_GAIN_THREE];

endmodule

`default_nettype wire

FILE: sv/rft_ctrl.sv
// ----------------------------------------------------------------------------
// rft_ctrl
// Sequencer that steps each upsampled value through the biquad sections.
// ----------------------------------------------------------------------------
`default_nettype none

module rft_ctrl #(
   parameter int SECTIONS = 3
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire rft_pkg::status_type status,
   output rft_pkg::cmd_type         cmd
);

   localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

   rft_pkg::state_type           state_ff, state_in;
   logic [SEC_W-1:0]             sec_ff, sec_in;
   logic [rft_pkg::UP_W-1:0]     up_ff, up_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rft_pkg::ST_IDLE;
         sec_ff   <= '0;
         up_ff    <= '0;
      end else begin
         state_ff <= state_in;
         sec_ff   <= sec_in;
         up_ff    <= up_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sec_in    = sec_ff;
      up_in     = up_ff;
      req_ready = 1'b0;
      cmd       = '0;
      if (int'(sec_ff) >= rft_pkg::COEF_REGS - 1) begin
         cmd.coef_sel = rft_pkg::SEL_W'(rft_pkg::COEF_REGS - 1);
      end else begin
         cmd.coef_sel = rft_pkg::SEL_W'(sec_ff);
      end
      case (state_ff)
         rft_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               sec_in     = '0;
               up_in      = '0;
               state_in   = rft_pkg::ST_MUL1;
            end
         end
         rft_pkg::ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = rft_pkg::ST_SUM;
         end
         rft_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = rft_pkg::ST_MUL2;
         end
         rft_pkg::ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = rft_pkg::ST_SAT;
         end
         rft_pkg::ST_SAT: begin
            cmd.sat = 1'b1;
            if (sec_ff == SEC_W'(SECTIONS - 1)) begin
               sec_in   = '0;
               state_in = rft_pkg::ST_EMIT;
            end else begin
               sec_in   = sec_ff + 1'b1;
               state_in = rft_pkg::ST_MUL1;
            end
         end
         rft_pkg::ST_EMIT: begin
            if (!status.phase_zero || status.out_free) begin
               cmd.emit    = status.phase_zero;
               cmd.advance = 1'b1;
               if (up_ff == rft_pkg::UP_W'(rft_pkg::UP_LAST)) begin
                  state_in = rft_pkg::ST_IDLE;
               end else begin
                  up_in    = up_ff + 1'b1;
                  state_in = rft_pkg::ST_MUL1;
               end
            end
         end
         default: begin
            state_in = rft_pkg::ST_IDLE;
         end
      endcase
   end

   a_emit_allowed: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.phase_zero && status.out_free)
      else $error("result written while not allowed");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == rft_pkg::ST_MUL1 && sec_ff == '0 && up_ff == '0)
      else $error("item did not start at the first section");

   a_last_section: assert property (@(posedge clock) disable iff (reset)
      state_ff == rft_pkg::ST_SAT && sec_ff == SEC_W'(SECTIONS - 1)
      |=> state_ff == rft_pkg::ST_EMIT)
      else $error("cascade end did not lead to emit");

   a_item_done: assert property (@(posedge clock) disable iff (reset)
      cmd.advance && up_ff == rft_pkg::UP_W'(rft_pkg::UP_LAST) |=> state_ff == rft_pkg::ST_IDLE)
      else $error("item did not finish after three upsampled values");

endmodule

`default_nettype wire

FILE: sv/rft_dp.sv
// ----------------------------------------------------------------------------
// rft_dp
// Datapath with one shared multiplier, section delay line and output word.
// ----------------------------------------------------------------------------
`default_nettype none

module rft_dp #(
   parameter int SECTIONS = 3
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire rft_pkg::cmd_type                     cmd,
   output rft_pkg::status_type                       status,
   input  wire logic signed [rft_pkg::SAMPLE_W-1:0]  req_in_sample,
   input  wire logic                                 req_start_of_buffer,
   input  wire rft_pkg::coef_type                    fb_coef [rft_pkg::COEF_REGS],
   input  wire rft_pkg::coef_type                    gain    [rft_pkg::COEF_REGS],
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_valid,
   output logic signed [rft_pkg::SAMPLE_W-1:0]       rsp_out_sample
);

   localparam int DW = rft_pkg::DATA_W;

   typedef struct packed {
      logic signed [DW-1:0] w1;
      logic signed [DW-1:0] w2;
   } delay_type;

   function automatic logic signed [DW-1:0] sat24(input logic signed [rft_pkg::SHIFT_W-1:0] v);
      logic signed [rft_pkg::SHIFT_W-1:0] hi;
      logic signed [rft_pkg::SHIFT_W-1:0] lo;
      hi = rft_pkg::SHIFT_W'(signed'(8388607));
      lo = rft_pkg::SHIFT_W'(signed'(-8388608));
      if (v > hi) begin
         sat24 = 24'sh7FFFFF;
      end else if (v < lo) begin
         sat24 = 24'sh800000;
      end else begin
         sat24 = v[DW-1:0];
      end
   endfunction

   delay_type                               sec_ff [SECTIONS];
   delay_type                               sec_in [SECTIONS];
   logic signed [DW-1:0]                    x_ff, x_in;
   logic signed [DW-1:0]                    wn_ff, wn_in;
   logic signed [rft_pkg::OP_W-1:0]         y_ff, y_in;
   logic signed [rft_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [rft_pkg::PHASE_W-1:0]             phase_ff, phase_in;
   logic signed [rft_pkg::SAMPLE_W-1:0]     out_ff, out_in;
   logic                                    out_valid_ff, out_valid_in;

   logic signed [rft_pkg::OP_W-1:0]         mul_a;
   logic signed [rft_pkg::SAMPLE_W-1:0]     mul_b;
   logic signed [rft_pkg::PROD_W-1:0]       mul_res;
   logic signed [rft_pkg::SHIFT_W-1:0]      prod_sh;
   logic signed [rft_pkg::SHIFT_W-1:0]      diff;
   logic signed [DW-1:0]                    wn_sat;
   logic signed [DW:0]                      round_x;
   logic signed [DW-6:0]                    quot;

   always_comb begin
      if (cmd.mul2) begin
         mul_a = y_ff;
         mul_b = signed'({1'b0, gain[cmd.coef_sel]});
      end else begin
         mul_a = rft_pkg::OP_W'(sec_ff[0].w2);
         mul_b = signed'({1'b0, fb_coef[cmd.coef_sel]});
      end
   end

   assign mul_res = mul_a * mul_b;
   assign prod_sh = prod_ff[rft_pkg::PROD_W-1:rft_pkg::FRAC_SH];
   assign diff    = rft_pkg::SHIFT_W'(x_ff) - prod_sh;
   assign wn_sat  = sat24(diff);
   assign round_x = (DW + 1)'(x_ff) + (x_ff[DW-1] ? (DW + 1)'(63) : (DW + 1)'(0));
   assign quot    = round_x[DW:6];

   always_comb begin
      sec_in       = sec_ff;
      x_in         = x_ff;
      wn_in        = wn_ff;
      y_in         = y_ff;
      prod_in      = prod_ff;
      phase_in     = phase_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;

      if (cmd.accept) begin
         x_in = DW'(req_in_sample) <<< 6;
         if (req_start_of_buffer) begin
            phase_in = '0;
         end
      end
      if (cmd.mul1 || cmd.mul2) begin
         prod_in = mul_res;
      end
      if (cmd.sum) begin
         wn_in = wn_sat;
         y_in  = rft_pkg::OP_W'(wn_sat) + {sec_ff[0].w1[DW-1], sec_ff[0].w1, 1'b0}
               + rft_pkg::OP_W'(sec_ff[0].w2);
      end
      if (cmd.sat) begin
         x_in = sat24(prod_sh);
         for (int i = 0; i < SECTIONS - 1; i++) begin
            sec_in[i] = sec_ff[i + 1];
         end
         sec_in[SECTIONS - 1].w1 = wn_ff;
         sec_in[SECTIONS - 1].w2 = sec_ff[0].w1;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         if (quot > (DW - 5)'(signed'(32767))) begin
            out_in = 16'sh7FFF;
         end else if (quot < (DW - 5)'(signed'(-32768))) begin
            out_in = 16'sh8000;
         end else begin
            out_in = quot[rft_pkg::SAMPLE_W-1:0];
         end
      end
      if (cmd.advance) begin
         phase_in = phase_ff + 1'b1;
         x_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SECTIONS; i++) begin
            sec_ff[i] <= '0;
         end
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sec_ff       <= sec_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      wn_ff   <= wn_in;
      y_ff    <= y_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

   assign status.phase_zero = (phase_ff == '0);
   assign status.out_free   = ~out_valid_ff | rsp_ready;
   assign rsp_valid         = out_valid_ff;
   assign rsp_out_sample    = out_ff;

endmodule

`default_nettype wire

FILE: sv/resample_four_thirds_iir.sv
// ----------------------------------------------------------------------------
// resample_four_thirds_iir
// Up-by-three, down-by-four audio resampler with a biquad low-pass cascade.
// ----------------------------------------------------------------------------
// The req channel takes one 16-bit sample per word, with a start-of-buffer
// flag that restarts the decimation phase. The rsp channel gives zero or one
// filtered word per input word. Each section has a feedback coefficient and a
// gain in the APB register bank; pready is always high.
// An input word passes through the cascade once for each of its three
// upsampled values: each section runs four steps around the single shared
// multiplier (feedback product, state update, gain product, saturation), and
// each upsampled value needs one further step that advances the decimation
// phase and, when the phase is zero, delivers its result.
// The next word is taken once the current one is done, even while a result
// still waits in the output register. If the receiver stalls, the sequencer
// holds before overwriting that register until the waiting word is taken.
// Reset clears the filter state, the decimation phase and the output valid,
// and loads the register defaults. Filter state persists across buffers.
// ----------------------------------------------------------------------------
`default_nettype none

module resample_four_thirds_iir #(
   parameter int SECTIONS = 3
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [rft_pkg::SAMPLE_W-1:0]  req_in_sample,
   input  wire logic                                 req_start_of_buffer,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [rft_pkg::SAMPLE_W-1:0]       rsp_out_sample,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [rft_pkg::ADDR_W-1:0]           paddr,
   input  wire logic [rft_pkg::PDATA_W-1:0]          pwdata,
   output logic      [rft_pkg::PDATA_W-1:0]          prdata,
   output logic                                      pready
);

   rft_pkg::coef_type    fb_coef [rft_pkg::COEF_REGS];
   rft_pkg::coef_type    gain    [rft_pkg::COEF_REGS];
   rft_pkg::cmd_type     cmd;
   rft_pkg::status_type  status;

   assign pready = 1'b1;

   rft_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .fb_coef (fb_coef),
      .gain    (gain)
   );

   rft_ctrl #(
      .SECTIONS (SECTIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rft_dp #(
      .SECTIONS (SECTIONS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_in_sample       (req_in_sample),
      .req_start_of_buffer (req_start_of_buffer),
      .fb_coef             (fb_coef),
      .gain                (gain),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_out_sample      (rsp_out_sample)
   );

endmodule

`default_nettype wire

FILE: tb/resample_checker.sv
// ----------------------------------------------------------------------------
// resample_checker
// Predicts and checks the result words of the four-thirds resampler.
// ----------------------------------------------------------------------------
// Watches the req, rsp and APB ports of the block. A shadow copy of the
// coefficient registers follows every write to them and checks every read.
// Each accepted req word runs through a bit-accurate model of the biquad
// cascade. The model zero-stuffs by three and keeps every fourth value, and
// the words that it emits wait in order. Each accepted rsp word is compared
// with the oldest waiting word. Mismatches and words with nothing waiting are
// counted, and the count and the number of waiting words are passed to the
// top.
// ----------------------------------------------------------------------------
module resample_checker #(
   parameter int SECTIONS = 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [rft_pkg::SAMPLE_W-1:0]  req_in_sample,
   input  logic                                 req_start_of_buffer,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [rft_pkg::SAMPLE_W-1:0]  rsp_out_sample,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rft_pkg::ADDR_W-1:0]           paddr,
   input  logic [rft_pkg::PDATA_W-1:0]          pwdata,
   input  logic [rft_pkg::PDATA_W-1:0]          prdata,
   input  logic                                 pready,
   output int                                   mismatch_count,
   output int                                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rft_pkg::*;

   localparam int     STATE_FRAC = 6;
   localparam longint STATE_HI   = 2**(DATA_W-1) - 1;
   localparam longint STATE_LO   = -(2**(DATA_W-1));
   localparam longint SAMPLE_HI  = 2**(SAMPLE_W-1) - 1;
   localparam longint SAMPLE_LO  = -(2**(SAMPLE_W-1));

   coef_type                   csr_shadow [NUM_REGS];
   logic signed [DATA_W-1:0]   w1_q [SECTIONS];
   logic signed [DATA_W-1:0]   w2_q [SECTIONS];
   logic [PHASE_W-1:0]         phase_q;
   logic signed [SAMPLE_W-1:0] due_samples [$];
   logic signed [SAMPLE_W-1:0] oldest;
   logic [IDX_W-1:0]           csr_index;
   int                         mismatch_total = 0;

   function automatic longint clamp_state(input longint v);
      if (v > STATE_HI) return STATE_HI;
      if (v < STATE_LO) return STATE_LO;
      return v;
   endfunction

   // One upsampled value through every section; the delay line is updated.
   function automatic longint run_sections(input longint x_in);
      longint x, a2, g, w1, w2, wn, y;
      int s, r;
      x = x_in;
      for (s = 0; s < SECTIONS; s++) begin
         r  = (s < COEF_REGS) ? s : COEF_REGS - 1;
         a2 = longint'(csr_shadow[r]);
         g  = longint'(csr_shadow[COEF_REGS + r]);
         w1 = longint'(w1_q[s]);
         w2 = longint'(w2_q[s]);
         wn = clamp_state(x - ((a2 * w2) >>> FRAC_SH));
         y  = wn + 2 * w1 + w2;
         w2_q[s] = w1_q[s];
         w1_q[s] = wn[DATA_W-1:0];
         x = clamp_state((y * g) >>> FRAC_SH);
      end
      return x;
   endfunction

   task automatic take_word(input logic signed [SAMPLE_W-1:0] smp, input logic sob);
      longint filtered, scaled;
      int k;
      if (sob) phase_q = '0;
      for (k = 0; k <= UP_LAST; k++) begin
         filtered = run_sections((k == 0) ? longint'(smp) * (2**STATE_FRAC) : 0);
         if (phase_q == '0) begin
            scaled = filtered / (2**STATE_FRAC);
            if (scaled > SAMPLE_HI) scaled = SAMPLE_HI;
            if (scaled < SAMPLE_LO) scaled = SAMPLE_LO;
            due_samples.push_back(scaled[SAMPLE_W-1:0]);
         end
         phase_q = phase_q + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (csr_shadow[i]) csr_shadow[i] = REG_RESET[i];
         foreach (w1_q[i]) begin
            w1_q[i] = '0;
            w2_q[i] = '0;
         end
         phase_q = '0;
         due_samples.delete();
      end else begin
         if (psel && penable && pready) begin
            csr_index = paddr[ADDR_W-1:2];
            if (csr_index < NUM_REGS) begin
               if (pwrite) begin
                  csr_shadow[csr_index] = pwdata[COEF_W-1:0];
               end else if (prdata !== PDATA_W'(csr_shadow[csr_index])) begin
                  $error("prdata: expected %0h, actual %0h",
                         PDATA_W'(csr_shadow[csr_index]), prdata);
                  mismatch_total++;
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (due_samples.size() == 0) begin
               $error("out_sample: expected no word, actual %0d", rsp_out_sample);
               mismatch_total++;
            end else begin
               oldest = due_samples.pop_front();
               if (rsp_out_sample !== oldest) begin
                  $error("out_sample: expected %0d, actual %0d", oldest, rsp_out_sample);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && req_ready) take_word(req_in_sample, req_start_of_buffer);
      end
      mismatch_count <= mismatch_total;
      pending_count  <= due_samples.size();
   end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the four-thirds resampler.
// ----------------------------------------------------------------------------
// Drives short directed samples at the rails and around the start-of-buffer
// flag, then buffers of random samples, under several coefficient settings
// written over APB while the block is idle. Both channels idle at random,
// with stretches of full rate. Prediction and checking are done by the
// checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rft_pkg::*;

   localparam int SECTIONS     = 3;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_WAIT     = 12;
   localparam int TIMEOUT_NS   = 5_000_000;
   localparam int DIRECTED_N   = 22;

   localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam coef_type COEF_MAX = '1;
   localparam coef_type COEF_MIN = '0;

   localparam logic [DIRECTED_N*SAMPLE_W-1:0] DIRECTED_SAMPLES = {
      16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
      16'h8000, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555,
      16'hAAAA, 16'h0064, 16'h00C8, 16'h012C, 16'hFED4, 16'h0000,
      16'h0000, 16'h0000, 16'h4000, 16'hC000
   };
   localparam logic [DIRECTED_N-1:0] DIRECTED_SOB = 22'b1000000000000110100010;

   typedef enum {FILL_FULL, FILL_SMALL, FILL_RAIL, FILL_MIXED} fill_type;

   logic                       clock               = 1'b0;
   logic                       reset               = 1'b1;
   logic                       req_valid           = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_in_sample       = '0;
   logic                       req_start_of_buffer = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready           = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_out_sample;
   logic                       psel                = 1'b0;
   logic                       penable             = 1'b0;
   logic                       pwrite              = 1'b0;
   logic [ADDR_W-1:0]          paddr               = '0;
   logic [PDATA_W-1:0]         pwdata              = '0;
   logic [PDATA_W-1:0]         prdata;
   logic                       pready;
   int                         fail_count;
   int                         pending;
   bit                         no_idle             = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   resample_four_thirds_iir #(
      .SECTIONS(SECTIONS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_sample(req_in_sample),
      .req_start_of_buffer(req_start_of_buffer),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_sample(rsp_out_sample),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   resample_checker #(
      .SECTIONS(SECTIONS)
   ) resample_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_sample(req_in_sample),
      .req_start_of_buffer(req_start_of_buffer),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_sample(rsp_out_sample),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .mismatch_count(fail_count),
      .pending_count(pending)
   );

   task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic sob);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_in_sample       <= smp;
      req_start_of_buffer <= sob;
      do @(posedge clock); while (!req_ready);
   endtask

   // Buffers of random length, most of them opened by the start flag.
   task automatic send_buffers(input int count);
      int sent, len, j;
      fill_type fill;
      logic signed [SAMPLE_W-1:0] level, smp;
      logic sob;
      sent = 0;
      while (sent < count) begin
         len     = $urandom_range(1, 24);
         fill    = fill_type'($urandom_range(0, 3));
         level   = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         no_idle = ($urandom_range(0, 4) == 0);
         for (j = 0; j < len && sent < count; j++) begin
            case (fill)
               FILL_FULL: begin
                  smp = SAMPLE_W'($urandom);
               end
               FILL_SMALL: begin
                  smp = SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
               end
               FILL_RAIL: begin
                  if ($urandom_range(0, 5) == 0) level = ~level;
                  smp = level;
               end
               default: begin
                  smp = ($urandom_range(0, 3) == 0) ? level : SAMPLE_W'($urandom);
               end
            endcase
            if (j == 0) sob = ($urandom_range(0, 7) != 0);
            else sob = ($urandom_range(0, 15) == 0);
            send_word(smp, sob);
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [IDX_W-1:0] idx,
                             input logic [PDATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_back();
      int k;
      for (k = 0; k < NUM_REGS; k++) csr_access(1'b0, IDX_W'(k), '0);
   endtask

   // The bits above the coefficient width are filled at random.
   task automatic apply_setting(input coef_type fb1, fb2, fb3, g1, g2, g3);
      wait_drained();
      csr_access(1'b1, REG_FB_ONE, {17'($urandom), fb1});
      csr_access(1'b1, REG_FB_TWO, {17'($urandom), fb2});
      csr_access(1'b1, REG_FB_THREE, {17'($urandom), fb3});
      csr_access(1'b1, REG_GAIN_ONE, {17'($urandom), g1});
      csr_access(1'b1, REG_GAIN_TWO, {17'($urandom), g2});
      csr_access(1'b1, REG_GAIN_THREE, {17'($urandom), g3});
      csr_access(1'b1, REG_SPARE_LO, $urandom);
      csr_access(1'b1, REG_SPARE_HI, $urandom);
      read_back();
   endtask

   function automatic coef_type random_coef();
      return coef_type'($urandom_range(0, 32767));
   endfunction

   initial begin : drain
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      int i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_back();
      for (i = 0; i < DIRECTED_N; i++) begin
         send_word(DIRECTED_SAMPLES[(DIRECTED_N-1-i)*SAMPLE_W +: SAMPLE_W],
                   DIRECTED_SOB[DIRECTED_N-1-i]);
      end
      send_buffers(100);
      apply_setting(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      send_buffers(120);
      apply_setting(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      send_buffers(120);
      apply_setting(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX);
      send_buffers(120);
      apply_setting(COEF_MAX, COEF_MAX, COEF_MAX, random_coef(), random_coef(),
                    random_coef());
      send_buffers(120);
      apply_setting(random_coef(), random_coef(), random_coef(), random_coef(),
                    random_coef(), random_coef());
      send_buffers(120);
      apply_setting(random_coef(), random_coef(), random_coef(), random_coef(),
                    random_coef(), random_coef());
      send_buffers(120);
      apply_setting(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, random_coef(), COEF_MAX);
      send_buffers(120);
      wait_drained();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule
